// ----- hdl/dlc_pkg.sv -----
// Shared types, constants and the character coder for the dinucleotide check.
// No dependencies; used by dlc_pair_ram and dinucleotide_low_complexity_check.
`default_nettype none

package dlc_pkg;

    localparam int NUM_CODES = 5;
    localparam int NUM_PAIRS = NUM_CODES * NUM_CODES;
    localparam int CODE_W    = 3;
    localparam int ADDR_W    = 5;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam code_t CODE_OTHER = 3'd0;
    localparam code_t CODE_A     = 3'd1;
    localparam code_t CODE_C     = 3'd2;
    localparam code_t CODE_G     = 3'd3;
    localparam code_t CODE_T     = 3'd4;

    localparam addr_t LAST_ADDR = addr_t'(NUM_PAIRS - 1);

    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
    } pair_mem_req_t;

    function automatic code_t char_code(input logic [7:0] ch);
        code_t c;
        case (ch)
            8'h41, 8'h61: c = CODE_A;
            8'h43, 8'h63: c = CODE_C;
            8'h47, 8'h67: c = CODE_G;
            8'h54, 8'h74: c = CODE_T;
            default:      c = CODE_OTHER;
        endcase
        return c;
    endfunction

    function automatic addr_t pair_addr(input code_t prev, input code_t cur);
        return addr_t'({prev, 2'b00}) + addr_t'(prev) + addr_t'(cur);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dlc_pair_ram.sv -----
// Pair counter memory: one write port, one registered read port, write-to-read forwarding.
// Depends on dlc_pkg.
`default_nettype none

module dlc_pair_ram #(
    parameter int CNT_W = 6
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  dlc_pkg::pair_mem_req_t    req,
    input  wire  [CNT_W-1:0]          wr_data,
    output logic [CNT_W-1:0]          rd_data
);

    logic [CNT_W-1:0] mem [dlc_pkg::NUM_PAIRS];
    logic [CNT_W-1:0] rd_data_reg;
    logic [CNT_W-1:0] fwd_data_reg;
    logic             fwd_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
        fwd_data_reg <= wr_data;
    end

    // forward a write that lands on the entry being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (req.rd_en)
        begin
            fwd_reg <= req.wr_en && (req.wr_addr == req.rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/dinucleotide_low_complexity_check.sv -----
// Dinucleotide low-complexity check: the top level, with control and top-three scan.
// Depends on dlc_pkg and dlc_pair_ram.
//
// Characters transfer at one per cycle within a sequence; each pair count is a
// read-modify-write of a 25-entry counter memory with forwarding between
// back-to-back updates. After the character that carries last_char, a scan
// reads all 25 entries of the counter memory, each read clearing its entry,
// then drains, decides and loads the output register. While that scan
// runs in_stall is high. A result waiting in the output register does not block
// the next sequence; only the next scan finish waits for it. After reset a
// pass clears the counter memory before the first character is taken.
`default_nettype none

module dinucleotide_low_complexity_check #(
    parameter int MAX_PAIRS = 50
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire  [7:0] char_byte,
    input  wire        last_char,
    output logic       out_valid,
    input  wire        out_stall,
    output logic       low_complexity
);

    localparam int CNT_W = $clog2(MAX_PAIRS + 2);
    localparam int SUM_W = CNT_W + 2;
    localparam int CMP_W = CNT_W + 4;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_PAIRS + 1);
    localparam logic [CNT_W-1:0] MAXP = CNT_W'(MAX_PAIRS);

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]          state_reg,    state_next;
    dlc_pkg::addr_t      cnt_reg,      cnt_next;
    dlc_pkg::code_t      prev_reg,     prev_next;
    logic                have_reg,     have_next;
    logic [CNT_W-1:0]    total_reg,    total_next;
    logic                upd_reg,      upd_next;
    dlc_pkg::addr_t      upd_addr_reg;
    logic                dv_reg,       dv_next;
    logic                out_valid_reg, out_valid_next;
    logic                low_reg,      low_next;
    logic [CNT_W-1:0]    first_reg,    first_next;
    logic [CNT_W-1:0]    second_reg,   second_next;
    logic [CNT_W-1:0]    third_reg,    third_next;

    dlc_pkg::pair_mem_req_t req;
    logic [CNT_W-1:0]       wr_data;
    logic [CNT_W-1:0]       rd_data;
    logic                   accept;
    dlc_pkg::code_t         code;
    dlc_pkg::addr_t         idx;
    logic [SUM_W-1:0]       sum;
    logic [CMP_W-1:0]       lhs;
    logic [CMP_W-1:0]       rhs;
    logic                   decide;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < CAP) ? v + CNT_W'(1) : CAP;
    endfunction

    dlc_pair_ram #(
        .CNT_W (CNT_W)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign in_stall = (state_reg != ST_RUN);
    assign accept   = in_valid && !in_stall;
    assign code     = dlc_pkg::char_code(char_byte);
    assign idx      = dlc_pkg::pair_addr(prev_reg, code);

    assign sum = SUM_W'(first_reg) + SUM_W'(second_reg) + SUM_W'(third_reg);
    assign lhs = {CMP_W'(sum)} << 2;
    assign rhs = (CMP_W'(total_reg) << 1) + CMP_W'(total_reg);
    assign decide = (total_reg != '0) && (total_reg <= MAXP) && (lhs > rhs);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        prev_next      = prev_reg;
        have_next      = have_reg;
        total_next     = total_reg;
        upd_next       = 1'b0;
        dv_next        = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        low_next       = low_reg;
        req            = '0;
        wr_data        = '0;

        // write port: clear pass, counter update, or clear behind the scan
        if (state_reg == ST_CLR)
        begin
            req.wr_en   = 1'b1;
            req.wr_addr = cnt_reg;
        end
        else if (upd_reg)
        begin
            req.wr_en   = 1'b1;
            req.wr_addr = upd_addr_reg;
            wr_data     = sat_inc(rd_data);
        end
        else if (dv_reg)
        begin
            req.wr_en   = 1'b1;
            req.wr_addr = cnt_reg - dlc_pkg::addr_t'(1);
        end

        case (state_reg)
            ST_CLR:
            begin
                cnt_next = cnt_reg + dlc_pkg::addr_t'(1);
                if (cnt_reg == dlc_pkg::LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    if (have_reg)
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = idx;
                        upd_next    = 1'b1;
                        total_next  = sat_inc(total_reg);
                    end
                    prev_next = code;
                    have_next = 1'b1;
                    if (last_char)
                    begin
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = cnt_reg;
                dv_next     = 1'b1;
                cnt_next    = cnt_reg + dlc_pkg::addr_t'(1);
                if (cnt_reg == dlc_pkg::LAST_ADDR)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    low_next       = decide;
                    prev_next      = dlc_pkg::CODE_OTHER;
                    have_next      = 1'b0;
                    total_next     = '0;
                    cnt_next       = '0;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_CLR;
                cnt_next   = '0;
            end
        endcase
    end

    // keep the three largest counts; ties fill separate slots
    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        third_next  = third_reg;
        if (state_reg == ST_RUN)
        begin
            first_next  = '0;
            second_next = '0;
            third_next  = '0;
        end
        else if (dv_reg)
        begin
            if (rd_data > first_reg)
            begin
                third_next  = second_reg;
                second_next = first_reg;
                first_next  = rd_data;
            end
            else if (rd_data > second_reg)
            begin
                third_next  = second_reg;
                second_next = rd_data;
            end
            else if (rd_data > third_reg)
            begin
                third_next = rd_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            cnt_reg       <= '0;
            prev_reg      <= dlc_pkg::CODE_OTHER;
            have_reg      <= 1'b0;
            total_reg     <= '0;
            upd_reg       <= 1'b0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            prev_reg      <= prev_next;
            have_reg      <= have_next;
            total_reg     <= total_next;
            upd_reg       <= upd_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upd_addr_reg <= idx;
        end
        first_reg  <= first_next;
        second_reg <= second_next;
        third_reg  <= third_next;
        low_reg    <= low_next;
    end

    assign out_valid      = out_valid_reg;
    assign low_complexity = low_reg;

endmodule

`default_nettype wire

// ----- hdl/dlc_checker.sv -----
// Port-level checks for the dinucleotide check, bound to its top level.
// Depends on dinucleotide_low_complexity_check.
`default_nettype none

module dlc_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_stall,
    input wire       last_char,
    input wire       out_valid,
    input wire       out_stall,
    input wire       low_complexity
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(low_complexity))
        else $error("stalled result changed");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_char |=> in_stall ##1 in_stall)
        else $error("input taken during end-of-sequence scan");

    a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared outside end-of-sequence scan");

endmodule

bind dinucleotide_low_complexity_check dlc_checker u_dlc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .last_char      (last_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .low_complexity (low_complexity)
);

`default_nettype wire
